>>> hdl/log_odds_occupancy_cell_update_macros.svh
// Assertion macros shared by the occupancy cell update RTL.
`ifndef LOG_ODDS_OCCUPANCY_CELL_UPDATE_MACROS_SVH
`define LOG_ODDS_OCCUPANCY_CELL_UPDATE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LOCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LOCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/locc_pkg.sv
// Types, constants and register codes for the occupancy cell update block.
package locc_pkg;

  localparam int unsigned CellCountDefault = 4096;
  localparam int unsigned QueueDepth       = 2;

  localparam int LoW    = 25;
  localparam int IdxW   = 12;
  localparam int OpW    = 3;
  localparam int StampW = 3;
  localparam int CycW   = 2;

  localparam logic [StampW-1:0] NewStamp   = 3'd4;
  localparam logic [CycW-1:0]   CycleFirst = 2'd1;
  localparam logic [CycW-1:0]   CycleLast  = 2'd3;

  localparam logic signed [LoW-1:0] LoMax = 25'sh0FFFFFF;
  localparam logic signed [LoW-1:0] LoMin = 25'sh1000000;

  localparam logic signed [LoW-1:0] HitIncReset    = 25'sd847297;
  localparam logic signed [LoW-1:0] MissIncReset   = -25'sd405465;
  localparam logic signed [LoW-1:0] ClampLowReset  = -25'sd1992430;
  localparam logic signed [LoW-1:0] ClampHighReset = 25'sd3476099;
  localparam logic signed [LoW-1:0] ThresholdReset = 25'sd0;

  typedef enum logic [OpW-1:0] {
    OP_HIT      = 3'd0,
    OP_MISS     = 3'd1,
    OP_RESET    = 3'd2,
    OP_QUERY    = 3'd3,
    OP_END_SCAN = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    K_HIT,
    K_MISS,
    K_RESET,
    K_QUERY,
    K_END_SCAN
  } kind_e;

  typedef enum logic [2:0] {
    REG_HIT_INC    = 3'd0,
    REG_MISS_INC   = 3'd1,
    REG_CLAMP_LOW  = 3'd2,
    REG_CLAMP_HIGH = 3'd3,
    REG_THRESHOLD  = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } back_state_e;

  typedef struct packed {
    logic signed [LoW-1:0] hit_inc;
    logic signed [LoW-1:0] miss_inc;
    logic signed [LoW-1:0] clamp_low;
    logic signed [LoW-1:0] clamp_high;
    logic signed [LoW-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    kind_e           kind;
    logic            in_range;
    logic [IdxW-1:0] index;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic signed [LoW-1:0] lo;
    logic [StampW-1:0]     stamp;
  } cell_t;

  typedef struct packed {
    logic                  vld;
    logic                  exists;
    logic signed [LoW-1:0] lo;
    logic [CycW-1:0]       cycle;
  } res_t;

endpackage

>>> hdl/locc_front.sv
// Front end: accepts commands, decodes them into work kinds and queues them.
module locc_front #(
  parameter int unsigned CELL_COUNT = locc_pkg::CellCountDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [locc_pkg::OpW-1:0]    opcode_i,
  input  logic [locc_pkg::IdxW-1:0]   cell_index_i,
  input  logic                        clearing_i,
  input  logic                        pop_i,
  output logic                        busy_o,
  output logic                        q_valid_o,
  output locc_pkg::item_t             q_item_o
);

  localparam int PtrW = (locc_pkg::QueueDepth > 1) ? $clog2(locc_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(locc_pkg::QueueDepth + 1);

  locc_pkg::item_t        q_mem_q [locc_pkg::QueueDepth];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        count_q, count_d;
  locc_pkg::item_t        item;
  logic                   in_range;
  logic                   push;
  logic                   full;

  // Out-of-range hit, miss and reset degrade to a query of an absent cell.
  always_comb begin
    in_range      = {20'd0, cell_index_i} < 32'(CELL_COUNT);
    item.in_range = in_range;
    item.index    = cell_index_i;
    case (opcode_i)
      locc_pkg::OP_HIT:      item.kind = in_range ? locc_pkg::K_HIT   : locc_pkg::K_QUERY;
      locc_pkg::OP_MISS:     item.kind = in_range ? locc_pkg::K_MISS  : locc_pkg::K_QUERY;
      locc_pkg::OP_RESET:    item.kind = in_range ? locc_pkg::K_RESET : locc_pkg::K_QUERY;
      locc_pkg::OP_END_SCAN: item.kind = locc_pkg::K_END_SCAN;
      default:               item.kind = locc_pkg::K_QUERY;
    endcase
  end

  assign full      = (count_q == CntW'(locc_pkg::QueueDepth));
  assign busy_o    = full | clearing_i;
  assign push      = start_i & ~busy_o;
  assign q_valid_o = (count_q != '0);
  assign q_item_o  = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(locc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(locc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

>>> hdl/locc_back.sv
// Back end: cell store, clearing pass, read-modify-write update and scan cycle.
module locc_back #(
  parameter int unsigned CELL_COUNT = locc_pkg::CellCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  locc_pkg::item_t   q_item_i,
  input  locc_pkg::cfg_t    cfg_i,
  output logic              pop_o,
  output logic              clearing_o,
  output locc_pkg::res_t    res_o
);

  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  locc_pkg::cell_t              mem_q [CELL_COUNT];
  locc_pkg::cell_t              rd_q;
  locc_pkg::cell_t              wr_data;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic                         we;

  locc_pkg::back_state_e        state_q, state_d;
  logic [AW-1:0]                clr_cnt_q, clr_cnt_d;
  locc_pkg::item_t              cur_q;
  logic [locc_pkg::CycW-1:0]    cycle_q, cycle_d, cycle_adv;
  logic                         pending_q, pending_d;
  locc_pkg::res_t               res_q, res_d;

  logic signed [locc_pkg::LoW-1:0] lo0, inc, sat, hit_lo, miss_lo, new_lo;
  logic signed [locc_pkg::LoW:0]   sum;
  logic [locc_pkg::StampW-1:0]     st0, new_st;
  logic                            stale;
  logic                            exists;

  assign rd_addr = AW'(q_item_i.index);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Shared adder for hit and miss, saturate, then one-sided clamp.
  always_comb begin
    lo0   = rd_q.valid ? rd_q.lo : '0;
    st0   = rd_q.valid ? rd_q.stamp : locc_pkg::NewStamp;
    stale = (st0 != {1'b0, cycle_q});
    inc   = (cur_q.kind == locc_pkg::K_HIT) ? cfg_i.hit_inc : cfg_i.miss_inc;
    sum   = {lo0[locc_pkg::LoW-1], lo0} + {inc[locc_pkg::LoW-1], inc};
    if (sum[locc_pkg::LoW] != sum[locc_pkg::LoW-1]) begin
      sat = sum[locc_pkg::LoW] ? locc_pkg::LoMin : locc_pkg::LoMax;
    end else begin
      sat = sum[locc_pkg::LoW-1:0];
    end
    hit_lo    = (sat > cfg_i.clamp_high) ? cfg_i.clamp_high : sat;
    miss_lo   = (sat < cfg_i.clamp_low) ? cfg_i.clamp_low : sat;
    cycle_adv = (cycle_q == locc_pkg::CycleLast) ? locc_pkg::CycleFirst
                                                 : cycle_q + locc_pkg::CycW'(1);
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    cycle_d   = cycle_q;
    pending_d = pending_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    wr_addr   = AW'(cur_q.index);
    new_lo    = lo0;
    new_st    = st0;
    exists    = cur_q.in_range & rd_q.valid;
    wr_data   = '0;
    res_d     = '0;
    case (state_q)
      locc_pkg::B_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_cnt_q;
        if (clr_cnt_q == AW'(CELL_COUNT - 1)) begin
          state_d = locc_pkg::B_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      locc_pkg::B_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = locc_pkg::B_EXEC;
        end
      end
      locc_pkg::B_EXEC: begin
        state_d = locc_pkg::B_IDLE;
        case (cur_q.kind)
          locc_pkg::K_HIT: begin
            we     = 1'b1;
            exists = 1'b1;
            if (stale) begin
              new_lo    = hit_lo;
              new_st    = {1'b0, cycle_q};
              pending_d = 1'b1;
            end
          end
          locc_pkg::K_MISS: begin
            we        = 1'b1;
            exists    = 1'b1;
            pending_d = 1'b1;
            new_st    = {1'b0, cycle_q};
            if (stale) begin
              new_lo = miss_lo;
            end
          end
          locc_pkg::K_RESET: begin
            we     = 1'b1;
            exists = 1'b1;
            new_lo = cfg_i.threshold;
            new_st = locc_pkg::NewStamp;
          end
          locc_pkg::K_END_SCAN: begin
            if (pending_q) begin
              cycle_d   = cycle_adv;
              pending_d = 1'b0;
            end
          end
          default: begin
          end
        endcase
        wr_data.valid = 1'b1;
        wr_data.lo    = new_lo;
        wr_data.stamp = new_st;
        res_d.vld     = 1'b1;
        res_d.exists  = exists;
        res_d.lo      = exists ? new_lo : '0;
        res_d.cycle   = cycle_d;
      end
      default: begin
        state_d = locc_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= locc_pkg::B_CLEAR;
      clr_cnt_q <= '0;
      cycle_q   <= locc_pkg::CycleFirst;
      pending_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      cycle_q   <= cycle_d;
      pending_q <= pending_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_item_i;
    end
  end

  assign clearing_o = (state_q == locc_pkg::B_CLEAR);
  assign res_o      = res_q;

endmodule

>>> hdl/locc_out.sv
// Result stage: classifies the updated log-odds against the threshold.
module locc_out (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  locc_pkg::res_t                    res_i,
  input  logic signed [locc_pkg::LoW-1:0]   threshold_i,
  output logic                              done_o,
  output logic                              cell_exists_o,
  output logic                              is_occupied_o,
  output logic                              is_free_o,
  output logic                              is_unknown_o,
  output logic signed [locc_pkg::LoW-1:0]   log_odds_o,
  output logic [locc_pkg::CycW-1:0]         scan_cycle_o
);

  logic gt, lt;

  assign gt = res_i.lo > threshold_i;
  assign lt = res_i.lo < threshold_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= res_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_exists_o <= res_i.exists;
    is_occupied_o <= res_i.exists & gt;
    is_free_o     <= res_i.exists & lt;
    is_unknown_o  <= ~res_i.exists | (~gt & ~lt);
    log_odds_o    <= res_i.lo;
    scan_cycle_o  <= res_i.cycle;
  end

endmodule

>>> hdl/log_odds_occupancy_cell_update.sv
// Top level of the log-odds occupancy cell update block.
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+-----------------------------------
//  command   | start in, busy out                 | opcode_i, cell_index_i
//  result    | done_o strobe, one cycle           | cell_exists_o .. scan_cycle_o
//  config    | psel, penable, pwrite, pready (=1) | paddr, pwdata, prdata
//
// An accepted command passes the queue, the cell store read, the back end result
// register and the output registers on its way to its done_o strobe, and waits longer
// while commands queued ahead of it are carried out. The back end reads the cell of
// a command in its idle state, updates it in its execute state and pops no other
// until it is back in idle. A two-entry queue sits between decode and update, so
// start is taken while the back end works; busy rises when that queue is full or
// during the clearing pass that walks the store after reset.
// The receiver cannot stall; every result goes out on its strobe cycle.
`include "log_odds_occupancy_cell_update_macros.svh"

module log_odds_occupancy_cell_update #(
  parameter int unsigned CELL_COUNT = locc_pkg::CellCountDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command transaction
  input  logic                              start,
  output logic                              busy,
  input  logic [locc_pkg::OpW-1:0]          opcode_i,
  input  logic [locc_pkg::IdxW-1:0]         cell_index_i,
  // result transaction
  output logic                              done_o,
  output logic                              cell_exists_o,
  output logic                              is_occupied_o,
  output logic                              is_free_o,
  output logic                              is_unknown_o,
  output logic signed [locc_pkg::LoW-1:0]   log_odds_o,
  output logic [locc_pkg::CycW-1:0]         scan_cycle_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  locc_pkg::cfg_t   cfg_q;
  locc_pkg::item_t  q_item;
  locc_pkg::res_t   res;
  logic             q_valid;
  logic             pop;
  logic             clearing;
  logic             cfg_wr;
  logic signed [locc_pkg::LoW-1:0] rd_val;

  // Configuration registers: written on the access phase of a write transaction.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_inc    <= locc_pkg::HitIncReset;
      cfg_q.miss_inc   <= locc_pkg::MissIncReset;
      cfg_q.clamp_low  <= locc_pkg::ClampLowReset;
      cfg_q.clamp_high <= locc_pkg::ClampHighReset;
      cfg_q.threshold  <= locc_pkg::ThresholdReset;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        locc_pkg::REG_HIT_INC:    cfg_q.hit_inc    <= pwdata[locc_pkg::LoW-1:0];
        locc_pkg::REG_MISS_INC:   cfg_q.miss_inc   <= pwdata[locc_pkg::LoW-1:0];
        locc_pkg::REG_CLAMP_LOW:  cfg_q.clamp_low  <= pwdata[locc_pkg::LoW-1:0];
        locc_pkg::REG_CLAMP_HIGH: cfg_q.clamp_high <= pwdata[locc_pkg::LoW-1:0];
        locc_pkg::REG_THRESHOLD:  cfg_q.threshold  <= pwdata[locc_pkg::LoW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back sign-extended to the bus width; unmapped addresses read zero.
  always_comb begin
    case (paddr[4:2])
      locc_pkg::REG_HIT_INC:    rd_val = cfg_q.hit_inc;
      locc_pkg::REG_MISS_INC:   rd_val = cfg_q.miss_inc;
      locc_pkg::REG_CLAMP_LOW:  rd_val = cfg_q.clamp_low;
      locc_pkg::REG_CLAMP_HIGH: rd_val = cfg_q.clamp_high;
      locc_pkg::REG_THRESHOLD:  rd_val = cfg_q.threshold;
      default:                  rd_val = '0;
    endcase
    prdata = {{(32 - locc_pkg::LoW){rd_val[locc_pkg::LoW-1]}}, rd_val};
  end

  // Decode and queue commands.
  locc_front #(
    .CELL_COUNT (CELL_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .opcode_i     (opcode_i),
    .cell_index_i (cell_index_i),
    .clearing_i   (clearing),
    .pop_i        (pop),
    .busy_o       (busy),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item)
  );

  // Read, update and write back the addressed cell; track the scan cycle.
  locc_back #(
    .CELL_COUNT (CELL_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .cfg_i      (cfg_q),
    .pop_o      (pop),
    .clearing_o (clearing),
    .res_o      (res)
  );

  // Classify and drive the result transaction.
  locc_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .threshold_i   (cfg_q.threshold),
    .done_o        (done_o),
    .cell_exists_o (cell_exists_o),
    .is_occupied_o (is_occupied_o),
    .is_free_o     (is_free_o),
    .is_unknown_o  (is_unknown_o),
    .log_odds_o    (log_odds_o),
    .scan_cycle_o  (scan_cycle_o)
  );

  // Exactly one classification flag per result.
  `LOCC_ASSERT_NOW(a_class_onehot, done_o,
                   $onehot({is_occupied_o, is_free_o, is_unknown_o}),
                   "result classification is not one-hot")
  // An absent cell reports zero log-odds.
  `LOCC_ASSERT_NOW(a_absent_zero, done_o && !cell_exists_o, log_odds_o == '0,
                   "absent cell reports nonzero log-odds")
  // The scan cycle never leaves the 1..3 range.
  `LOCC_ASSERT_NOW(a_cycle_range, done_o, scan_cycle_o != '0,
                   "scan cycle reported as zero")
  // The back end returns to idle after each command before it pops another, so strobes never abut.
  `LOCC_ASSERT_NEXT(a_strobe_spacing, done_o, !done_o,
                    "result strobes on consecutive cycles")

endmodule

>>> verif/locc_cell_checker.sv
// Checker for the occupancy cell update block: tracks cells, predicts and compares.
module locc_cell_checker #(
  parameter int unsigned CELL_COUNT = locc_pkg::CellCountDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [locc_pkg::OpW-1:0]        opcode_i,
  input  logic [locc_pkg::IdxW-1:0]       cell_index_i,
  input  logic                            done_i,
  input  logic                            cell_exists_i,
  input  logic                            is_occupied_i,
  input  logic                            is_free_i,
  input  logic                            is_unknown_i,
  input  logic signed [locc_pkg::LoW-1:0] log_odds_i,
  input  logic [locc_pkg::CycW-1:0]       scan_cycle_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [4:0]                      paddr_i,
  input  logic [31:0]                     pwdata_i,
  input  logic [31:0]                     prdata_i,
  output int                              error_count_o,
  output int                              reports_due_o
);
  import locc_pkg::*;

  typedef struct packed {
    logic                  exists;
    logic                  occupied;
    logic                  free;
    logic                  unknown;
    logic signed [LoW-1:0] lo;
    logic [CycW-1:0]       cycle;
  } cell_report_t;

  typedef struct {
    logic [OpW-1:0]  op;
    logic [IdxW-1:0] idx;
    cell_report_t    want;
  } report_due_t;

  report_due_t reports_due[$];

  logic                  cell_made  [CELL_COUNT];
  logic signed [LoW-1:0] cell_lo    [CELL_COUNT];
  logic [StampW-1:0]     cell_stamp [CELL_COUNT];
  logic [CycW-1:0]       scan_cycle;
  logic                  scan_open;

  logic signed [LoW-1:0] hit_step, miss_step, floor_lo, ceiling_hi, threshold;

  int           mismatches = 0;
  int           due_count  = 0;
  cell_report_t seen;
  report_due_t  oldest;

  assign error_count_o = mismatches;
  assign reports_due_o = due_count;

  task automatic report_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  function automatic logic signed [LoW-1:0] saturate(input int s);
    if (s > int'(LoMax)) return LoMax;
    if (s < int'(LoMin)) return LoMin;
    return LoW'(s);
  endfunction

  function automatic logic signed [LoW-1:0] setting_of(input reg_e r);
    case (r)
      REG_HIT_INC:    return hit_step;
      REG_MISS_INC:   return miss_step;
      REG_CLAMP_LOW:  return floor_lo;
      REG_CLAMP_HIGH: return ceiling_hi;
      REG_THRESHOLD:  return threshold;
      default:        return '0;
    endcase
  endfunction

  task automatic write_setting(input reg_e r, input logic signed [LoW-1:0] v);
    case (r)
      REG_HIT_INC:    hit_step   = v;
      REG_MISS_INC:   miss_step  = v;
      REG_CLAMP_LOW:  floor_lo   = v;
      REG_CLAMP_HIGH: ceiling_hi = v;
      REG_THRESHOLD:  threshold  = v;
      default: ;
    endcase
  endtask

  // A new cell starts at zero log-odds, stamped so that the first hit or miss applies.
  task automatic touch_cell(input logic [IdxW-1:0] idx);
    if (!cell_made[idx]) begin
      cell_made[idx]  = 1'b1;
      cell_lo[idx]    = '0;
      cell_stamp[idx] = NewStamp;
    end
  endtask

  task automatic update_cell(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx,
                             output cell_report_t rep);
    logic                  in_range;
    logic signed [LoW-1:0] sum;
    in_range = idx < CELL_COUNT;
    case (op)
      OP_END_SCAN: begin
        if (scan_open) begin
          scan_cycle = (scan_cycle == CycleLast) ? CycleFirst : scan_cycle + 1'b1;
          scan_open  = 1'b0;
        end
      end
      OP_HIT: begin
        if (in_range) begin
          touch_cell(idx);
          if (cell_stamp[idx] != {1'b0, scan_cycle}) begin
            sum             = saturate(int'(cell_lo[idx]) + int'(hit_step));
            cell_lo[idx]    = (sum < ceiling_hi) ? sum : ceiling_hi;
            cell_stamp[idx] = {1'b0, scan_cycle};
            scan_open       = 1'b1;
          end
        end
      end
      OP_MISS: begin
        if (in_range) begin
          touch_cell(idx);
          if (cell_stamp[idx] != {1'b0, scan_cycle}) begin
            sum          = saturate(int'(cell_lo[idx]) + int'(miss_step));
            cell_lo[idx] = (sum > floor_lo) ? sum : floor_lo;
          end
          cell_stamp[idx] = {1'b0, scan_cycle};
          scan_open       = 1'b1;
        end
      end
      OP_RESET: begin
        if (in_range) begin
          touch_cell(idx);
          cell_lo[idx]    = threshold;
          cell_stamp[idx] = NewStamp;
        end
      end
      default: ;
    endcase
    rep.exists   = in_range && cell_made[idx];
    rep.lo       = rep.exists ? cell_lo[idx] : '0;
    rep.occupied = rep.exists && (rep.lo > threshold);
    rep.free     = rep.exists && (rep.lo < threshold);
    rep.unknown  = !rep.exists || (rep.lo == threshold);
    rep.cycle    = scan_cycle;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CELL_COUNT; k++) begin
        cell_made[k]  = 1'b0;
        cell_lo[k]    = '0;
        cell_stamp[k] = '0;
      end
      scan_cycle = CycleFirst;
      scan_open  = 1'b0;
      hit_step   = HitIncReset;
      miss_step  = MissIncReset;
      floor_lo   = ClampLowReset;
      ceiling_hi = ClampHighReset;
      threshold  = ThresholdReset;
      reports_due.delete();
      due_count  = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          write_setting(reg_e'(paddr_i[4:2]), pwdata_i[LoW-1:0]);
        end else if (prdata_i[LoW-1:0] !== setting_of(reg_e'(paddr_i[4:2]))) begin
          report_failure($sformatf("register read at 0x%0h: expected %0d, got %0d",
                                   paddr_i, setting_of(reg_e'(paddr_i[4:2])),
                                   $signed(prdata_i[LoW-1:0])));
        end
      end
      // Compare results before taking a new command: none can finish on its own edge.
      if (done_i) begin
        seen = {cell_exists_i, is_occupied_i, is_free_i, is_unknown_i, log_odds_i,
                scan_cycle_i};
        if (reports_due.size() == 0) begin
          report_failure($sformatf("result with no command outstanding: exists=%b lo=%0d",
                                   seen.exists, $signed(seen.lo)));
        end else begin
          oldest = reports_due.pop_front();
          if (seen !== oldest.want) begin
            report_failure($sformatf({"op %0d cell %0d: expected exists=%b occ=%b free=%b ",
              "unk=%b lo=%0d cyc=%0d, got exists=%b occ=%b free=%b unk=%b lo=%0d cyc=%0d"},
              oldest.op, oldest.idx, oldest.want.exists, oldest.want.occupied,
              oldest.want.free, oldest.want.unknown, $signed(oldest.want.lo),
              oldest.want.cycle, seen.exists, seen.occupied, seen.free, seen.unknown,
              $signed(seen.lo), seen.cycle));
          end
        end
      end
      if (start_i && !busy_i) begin
        oldest.op  = opcode_i;
        oldest.idx = cell_index_i;
        update_cell(opcode_i, cell_index_i, oldest.want);
        reports_due = {reports_due, oldest};
      end
      due_count = reports_due.size();
    end
  end

endmodule

>>> verif/tb.sv
// Top of the occupancy cell update testbench: clock, reset, stimulus and verdict.
module tb;
  import locc_pkg::*;

  localparam int unsigned CellCount     = CellCountDefault;
  localparam int          CycleLimit    = 200000;
  localparam int          RandomPhases  = 5;
  localparam int          ItemsPerPhase = 370;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start        = 1'b0;
  logic [OpW-1:0]        opcode_i     = '0;
  logic [IdxW-1:0]       cell_index_i = '0;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [4:0]            paddr        = '0;
  logic [31:0]           pwdata       = '0;

  logic                  busy;
  logic                  done_o;
  logic                  cell_exists_o;
  logic                  is_occupied_o;
  logic                  is_free_o;
  logic                  is_unknown_o;
  logic signed [LoW-1:0] log_odds_o;
  logic [CycW-1:0]       scan_cycle_o;
  logic [31:0]           prdata;
  logic                  pready;

  int              error_count;
  int              reports_due;
  int              cycle_count = 0;
  int              burst_left  = 1;
  logic [IdxW-1:0] pool_base   = '0;

  log_odds_occupancy_cell_update #(.CELL_COUNT(CellCount)) dut (
    .clk_i, .rst_ni,
    .start, .busy, .opcode_i, .cell_index_i,
    .done_o, .cell_exists_o, .is_occupied_o, .is_free_o, .is_unknown_o,
    .log_odds_o, .scan_cycle_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  locc_cell_checker #(.CELL_COUNT(CellCount)) u_checker (
    .clk_i, .rst_ni,
    .start_i(start), .busy_i(busy), .opcode_i, .cell_index_i,
    .done_i(done_o), .cell_exists_i(cell_exists_o), .is_occupied_i(is_occupied_o),
    .is_free_i(is_free_o), .is_unknown_i(is_unknown_o), .log_odds_i(log_odds_o),
    .scan_cycle_i(scan_cycle_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .prdata_i(prdata),
    .error_count_o(error_count), .reports_due_o(reports_due)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bound the run: the clearing pass plus every command at its slowest pace fits
  // many times over below this count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drop start and hold off until the checker has seen every result come back.
  task automatic drain();
    @(negedge clk_i) start <= 1'b0;
    while (reports_due != 0) @(negedge clk_i);
  endtask

  // Drain, then let the pipeline go quiet before touching the registers.
  task automatic settle();
    drain();
    repeat (4) @(negedge clk_i);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk_i) start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Close a burst when its count runs out: stretches run back to back, some end in a
  // short gap, a few wait for the block to drain completely.
  task automatic pace();
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0:       drain();
        1, 2, 3: ;
        default: idle_cycles($urandom_range(1, 6));
      endcase
    end
  endtask

  // Present one command transaction; it is taken at the edge where busy is low.
  task automatic issue(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx);
    @(negedge clk_i);
    start        <= 1'b1;
    opcode_i     <= op;
    cell_index_i <= idx;
    do @(posedge clk_i); while (busy);
    pace();
  endtask

  // Setup cycle, then access cycle; psel is released by the caller after the last access.
  task automatic apb_access(input logic wr, input reg_e r, input logic signed [LoW-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= {{(32 - LoW){v[LoW-1]}}, v};
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic read_back_all();
    for (int k = 0; k <= REG_THRESHOLD; k++) apb_access(1'b0, reg_e'(k), '0);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_config(input logic signed [LoW-1:0] hit, miss, lo, hi, thr);
    settle();
    apb_access(1'b1, REG_HIT_INC, hit);
    apb_access(1'b1, REG_MISS_INC, miss);
    apb_access(1'b1, REG_CLAMP_LOW, lo);
    apb_access(1'b1, REG_CLAMP_HIGH, hi);
    apb_access(1'b1, REG_THRESHOLD, thr);
    read_back_all();
  endtask

  // Moderate values and full-width noise in equal shares, with the range ends mixed in.
  function automatic logic signed [LoW-1:0] pick_setting();
    case ($urandom_range(0, 9))
      0:          return LoMax;
      1:          return LoMin;
      2, 3, 4, 5: return LoW'(int'($urandom_range(0, 4000000)) - 2000000);
      default:    return LoW'($urandom);
    endcase
  endfunction

  // Keep most traffic on a small window of cells so stamps and scans interact.
  function automatic logic [IdxW-1:0] pick_cell();
    if ($urandom_range(0, 4) != 0) return pool_base + IdxW'($urandom_range(0, 15));
    return IdxW'($urandom_range(0, CellCount - 1));
  endfunction

  // One sensor scan: a run of hits and misses with some noise, closed by end of scan.
  task automatic random_scan(inout int sent);
    int r;
    repeat ($urandom_range(3, 40)) begin
      r = $urandom_range(0, 99);
      if (r < 40)      issue(OP_HIT, pick_cell());
      else if (r < 72) issue(OP_MISS, pick_cell());
      else if (r < 82) issue(OP_QUERY, pick_cell());
      else if (r < 88) issue(OP_RESET, pick_cell());
      else if (r < 92) issue(OpW'($urandom_range(5, 7)), IdxW'($urandom));
      else if (r < 95) issue(OP_END_SCAN, IdxW'($urandom));
      else             issue(OP_HIT, IdxW'($urandom));
      sent++;
    end
    issue(OP_END_SCAN, pick_cell());
    sent++;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0:       pool_base = '0;
        1:       pool_base = IdxW'(CellCount - 16);
        default: pool_base = IdxW'($urandom_range(0, CellCount - 16));
      endcase
    end
  endtask

  initial begin
    int sent;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // Hold off through the clearing pass, then check the reset register values.
    do @(posedge clk_i); while (busy);
    read_back_all();

    // Reset settings: creation, stamping, pending scan and cycle advance.
    issue(OP_QUERY, '0);
    issue(OP_END_SCAN, '0);
    issue(OP_HIT, '0);
    issue(OP_HIT, '0);
    issue(OP_MISS, '0);
    issue(OP_MISS, '1);
    issue(OP_END_SCAN, 12'hAAA);
    issue(OP_HIT, '0);
    issue(OP_RESET, '1);
    issue(OP_QUERY, '1);
    issue(3'd5, '0);
    issue(3'd6, 12'h555);
    issue(3'd7, '1);
    issue(OP_END_SCAN, '0);
    issue(OP_HIT, 12'hAAA);
    issue(OP_END_SCAN, '0);

    // Range ends: sums saturate in both directions, threshold at the bottom.
    program_config(LoMax, LoMin, LoMin, LoMax, LoMin);
    issue(OP_HIT, 12'd1);
    issue(OP_END_SCAN, '0);
    issue(OP_HIT, 12'd1);
    issue(OP_MISS, 12'd2);
    issue(OP_END_SCAN, '0);
    issue(OP_MISS, 12'd2);

    // Crossed bounds: each update applies only its own bound.
    program_config(25'sd5000, -25'sd5000, 25'sd100000, -25'sd100000, '0);
    issue(OP_HIT, 12'd3);
    issue(OP_END_SCAN, '0);
    issue(OP_MISS, 12'd3);

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       program_config(HitIncReset, MissIncReset, ClampLowReset, ClampHighReset,
                                ThresholdReset);
        2:       program_config(LoMin, LoMax, LoMax, LoMin, LoMax);
        default: program_config(pick_setting(), pick_setting(), pick_setting(),
                                pick_setting(), pick_setting());
      endcase
      sent = 0;
      while (sent < ItemsPerPhase) random_scan(sent);
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
